FILE: rtl/core/pfde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfde_pkg;

  localparam logic [7:0] PIX_MASK = 8'h80;
  localparam logic [7:0] ALL_ONES = 8'hFF;
  localparam logic [7:0] ALL_ZEROS = 8'h00;
  localparam logic [2:0] LAST_BIT = 3'd7;
  localparam int PAGE_W = 5;

  typedef enum logic [2:0] {
    K_PLOT  = 3'd0,
    K_FILL  = 3'd1,
    K_BLIT  = 3'd2,
    K_CLEAR = 3'd3,
    K_READ  = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_CALC,
    S_RD,
    S_WR,
    S_CLEAR,
    S_RDMEM,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic calc;
    logic mem_rd;
    logic mem_wr;
    logic step;
    logic clr_write;
    logic clr_ink;
    logic rd_index;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       fill_empty;
    logic       last;
    logic       clr_last;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/pfde_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pfde_ctrl
  import pfde_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts_i.kind)
          K_PLOT:  state_d = S_CALC;
          K_BLIT:  state_d = S_CALC;
          K_FILL:  state_d = sts_i.fill_empty ? S_DONE : S_CALC;
          K_CLEAR: state_d = S_CLEAR;
          K_READ:  state_d = S_RDMEM;
          default: state_d = S_DONE;
        endcase
      end
      S_CALC:  state_d = S_RD;
      S_RD:    state_d = S_WR;
      S_WR: begin
        state_d = sts_i.last ? S_DONE : S_CALC;
      end
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_DONE;
      end
      S_RDMEM: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_write = 1'b1;
      end
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_CALC:  cmd_o.calc = 1'b1;
      S_RD:    cmd_o.mem_rd = 1'b1;
      S_WR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.step   = 1'b1;
      end
      S_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        cmd_o.clr_ink   = 1'b1;
      end
      S_RDMEM: cmd_o.rd_index = 1'b1;
      S_DONE:  cmd_o.result = 1'b1;
      default: cmd_o = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> ($past(state_q) == S_RD))
    else $error("write phase without a read phase");

  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && sts_i.clr_last) |=> (state_q == S_DONE))
    else $error("clear sweep did not finish");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/pfde_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pfde_datapath
  import pfde_pkg::*;
#(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  wire  [2:0]  kind_i,
  input  wire  [7:0]  x_start_i,
  input  wire  [7:0]  y_start_i,
  input  wire  [7:0]  x_end_i,
  input  wire  [7:0]  y_end_i,
  input  wire         ink_i,
  input  wire  [7:0]  data_byte_i,
  input  wire  [7:0]  image_height_i,
  input  wire         start_of_image_i,
  input  wire  [9:0]  read_index_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        clipped_o
);

  localparam int PAGES = (HEIGHT + 7) / 8;
  localparam int STORE = WIDTH * PAGES;
  localparam int AW    = $clog2(STORE);
  localparam int RIW   = (AW > 10) ? AW : 10;

  logic [7:0] mem [STORE];

  logic [2:0]        kind_q;
  logic [7:0]        xs_q, ys_q, x1c_q, y1c_q, height_q, data_q;
  logic              ink_q;
  logic [RIW-1:0]    ridx_q;
  logic [7:0]        col_q, col_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [7:0]        cursor_q, cursor_d;
  logic [7:0]        row_off_q, row_off_d;
  logic [2:0]        bit_q, bit_d;
  logic [AW-1:0]     clr_addr_q;
  logic [AW-1:0]     addr_q, addr_d;
  logic [7:0]        mask_q, mask_d;
  logic              val_q, val_d;
  logic              onscreen_q, onscreen_d;
  logic [7:0]        rdata_q;
  logic              done_q;
  logic [7:0]        read_data_q;
  logic              clipped_q;

  logic [PAGE_W-1:0] page_first, page_end;
  logic [7:0]        row_off_inc;
  logic              wrap;
  logic              clr_last;
  logic              in_range;
  logic [7:0]        pix_col, pix_row;
  logic [PAGE_W-1:0] pix_page;
  logic [2:0]        lo_row, hi_row;
  logic              mem_we, mem_re;
  logic [AW-1:0]     waddr, raddr;
  logic [7:0]        wdata, merged;

  assign page_first  = ys_q[7:3];
  assign page_end    = y1c_q[7:3];
  assign row_off_inc = row_off_q + 8'd1;
  assign wrap        = (row_off_inc == height_q);
  assign clr_last    = (clr_addr_q == AW'(STORE - 1));
  assign in_range    = ({1'b0, ridx_q} < (RIW + 1)'(STORE));

  always_comb begin
    sts_o            = '0;
    sts_o.kind       = kind_q;
    sts_o.fill_empty = (xs_q > x1c_q) || (ys_q > y1c_q);
    sts_o.clr_last   = clr_last;
    case (kind_q)
      K_FILL:  sts_o.last = (col_q == x1c_q) && (page_q == page_end);
      K_BLIT:  sts_o.last = (bit_q == LAST_BIT) || wrap;
      default: sts_o.last = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      xs_q     <= x_start_i;
      ys_q     <= y_start_i;
      x1c_q    <= (x_end_i > 8'(WIDTH - 1)) ? 8'(WIDTH - 1) : x_end_i;
      y1c_q    <= (y_end_i > 8'(HEIGHT - 1)) ? 8'(HEIGHT - 1) : y_end_i;
      ink_q    <= ink_i;
      height_q <= image_height_i;
      ridx_q   <= RIW'(read_index_i);
    end
  end

  always_comb begin
    col_d     = col_q;
    page_d    = page_q;
    cursor_d  = cursor_q;
    row_off_d = row_off_q;
    bit_d     = bit_q;
    if (cmd_i.load) begin
      col_d  = x_start_i;
      page_d = y_start_i[7:3];
      bit_d  = 3'd0;
      if (kind_i == K_BLIT && start_of_image_i) begin
        cursor_d  = 8'd0;
        row_off_d = 8'd0;
      end
    end else if (cmd_i.step) begin
      case (kind_q)
        K_FILL: begin
          if (page_q == page_end) begin
            page_d = page_first;
            col_d  = col_q + 8'd1;
          end else begin
            page_d = page_q + PAGE_W'(1);
          end
        end
        K_BLIT: begin
          bit_d = bit_q + 3'd1;
          if (wrap) begin
            row_off_d = 8'd0;
            cursor_d  = cursor_q + 8'd1;
          end else begin
            row_off_d = row_off_inc;
          end
        end
        default: bit_d = bit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      page_q      <= '0;
      cursor_q    <= '0;
      row_off_q   <= '0;
      bit_q       <= '0;
      clr_addr_q  <= '0;
      done_q      <= 1'b0;
      read_data_q <= '0;
      clipped_q   <= 1'b0;
    end else begin
      col_q     <= col_d;
      page_q    <= page_d;
      cursor_q  <= cursor_d;
      row_off_q <= row_off_d;
      bit_q     <= bit_d;
      if (cmd_i.clr_write) begin
        clr_addr_q <= clr_last ? '0 : clr_addr_q + AW'(1);
      end
      done_q      <= cmd_i.result;
      read_data_q <= (cmd_i.result && kind_q == K_READ && in_range) ? rdata_q : ALL_ZEROS;
      clipped_q   <= cmd_i.result && kind_q == K_PLOT && !onscreen_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      data_q <= data_byte_i;
    end else if (cmd_i.step && kind_q == K_BLIT) begin
      data_q <= {data_q[6:0], 1'b0};
    end
  end

  always_comb begin
    pix_col = xs_q;
    pix_row = ys_q;
    val_d   = ink_q;
    if (kind_q == K_BLIT) begin
      pix_col = xs_q + cursor_q;
      pix_row = ys_q + row_off_q;
      val_d   = data_q[7] ? ink_q : !ink_q;
    end
    lo_row = (page_q == page_first) ? ys_q[2:0] : 3'd0;
    hi_row = (page_q == page_end) ? y1c_q[2:0] : LAST_BIT;
    if (kind_q == K_FILL) begin
      pix_page   = page_q;
      onscreen_d = 1'b1;
      mask_d     = (ALL_ONES >> lo_row) & (ALL_ONES << (LAST_BIT - hi_row));
      addr_d     = AW'(32'(page_q) * WIDTH + 32'(col_q));
    end else begin
      pix_page   = pix_row[7:3];
      onscreen_d = ({1'b0, pix_col} < 9'(WIDTH)) && ({1'b0, pix_row} < 9'(HEIGHT));
      mask_d     = PIX_MASK >> pix_row[2:0];
      addr_d     = AW'(32'(pix_page) * WIDTH + 32'(pix_col));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      addr_q     <= addr_d;
      mask_q     <= mask_d;
      val_q      <= val_d;
      onscreen_q <= onscreen_d;
    end
  end

  assign merged = val_q ? (rdata_q | mask_q) : (rdata_q & ~mask_q);
  assign mem_we = (cmd_i.mem_wr && onscreen_q) || cmd_i.clr_write;
  assign waddr  = cmd_i.clr_write ? clr_addr_q : addr_q;
  assign wdata  = cmd_i.clr_write ? ((cmd_i.clr_ink && ink_q) ? ALL_ONES : ALL_ZEROS)
                                  : merged;
  assign mem_re = cmd_i.mem_rd || cmd_i.rd_index;
  assign raddr  = cmd_i.rd_index ? ridx_q[AW-1:0] : addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign done_o      = done_q;
  assign read_data_o = read_data_q;
  assign clipped_o   = clipped_q;

`ifndef ASSERT_OFF
  a_done_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.result))
    else $error("result word without a result command");

  a_payload_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clipped_q || read_data_q != 8'd0) |-> done_q)
    else $error("result fields set outside a result word");

  a_clip_plot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clipped_q |-> (kind_q == K_PLOT))
    else $error("clipped flag on a word that is not a plot");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/page_framebuffer_draw_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Monochrome page framebuffer draw engine, WIDTH by HEIGHT pixels in 8-row pages.
// A command word is taken on a clock edge where start is high and busy is low.
// Every command gives exactly one result word: done_o is high for one cycle with
// read_data_o and clipped_o; the receiver cannot stall it and must take it then.
// Each word runs through the controller states: dispatch, then for each pixel,
// blit bit or fill byte a calc, read and write state doing a read-modify-write
// of the frame memory, then done. A read does one memory read, an empty fill or
// an unused kind goes straight to done, and a clear or set sweeps every byte of
// the frame memory, WIDTH * ceil(HEIGHT / 8) bytes, before done.
// Busy drops in the done_o cycle, so the next word may be taken there.
// After reset the frame memory is zeroed by a sweep over all its bytes,
// one byte per cycle, during which busy stays high. The blit cursor
// is cleared at reset and by a blit word with start_of_image set.

module page_framebuffer_draw_engine_top
  import pfde_pkg::*;
#(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start,
  output logic       busy,
  input  wire  [2:0] kind_i,
  input  wire  [7:0] x_start_i,
  input  wire  [7:0] y_start_i,
  input  wire  [7:0] x_end_i,
  input  wire  [7:0] y_end_i,
  input  wire        ink_i,
  input  wire  [7:0] data_byte_i,
  input  wire  [7:0] image_height_i,
  input  wire        start_of_image_i,
  input  wire  [9:0] read_index_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic       clipped_o
);

  cmd_t cmd;
  sts_t sts;

  pfde_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pfde_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .kind_i           (kind_i),
    .x_start_i        (x_start_i),
    .y_start_i        (y_start_i),
    .x_end_i          (x_end_i),
    .y_end_i          (y_end_i),
    .ink_i            (ink_i),
    .data_byte_i      (data_byte_i),
    .image_height_i   (image_height_i),
    .start_of_image_i (start_of_image_i),
    .read_index_i     (read_index_i),
    .done_o           (done_o),
    .read_data_o      (read_data_o),
    .clipped_o        (clipped_o)
  );

endmodule

`default_nettype wire
